[design/fdtd_pkg.sv]
// Shared types and constants for the 1-D lossy FDTD grid.
`timescale 1ns / 1ps
package fdtd_pkg;

  // Default grid geometry.
  localparam int CELLS_DEF      = 64;
  localparam int FIELD_BITS_DEF = 24;

  // Widths of the port fields.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int DSTART_BITS   = 6;
  localparam int GAIN_A_BITS   = 17;
  localparam int GAIN_B_BITS   = 24;
  localparam int IO_BITS       = 24;
  localparam int IDX_BITS      = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_DIEL_START = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_A     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_B     = 2'd2;

  // Register reset values.
  localparam logic [DSTART_BITS-1:0] DSTART_RST = 6'd32;
  localparam logic [GAIN_A_BITS-1:0] GAIN_A_RST = 17'd65536;
  localparam logic [GAIN_B_BITS-1:0] GAIN_B_RST = 24'd0;

  // Input command codes.
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Phase strobes broadcast to every cell.
  typedef struct packed {
    logic flux;
    logic efld;
    logic cond;
    logic magn;
  } fdtd_ctl_t;

endpackage

[design/fdtd_cell.sv]
// One grid cell: holds D, E, I and H and updates them phase by phase.
`timescale 1ns / 1ps
module fdtd_cell #(
  parameter int W     = fdtd_pkg::FIELD_BITS_DEF,
  parameter int IDX   = 1,
  parameter int CELLS = fdtd_pkg::CELLS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fdtd_pkg::fdtd_ctl_t                    ctl_i,
  input  logic [fdtd_pkg::DSTART_BITS-1:0]       diel_start_i,
  input  logic [fdtd_pkg::GAIN_A_BITS-1:0]       gain_a_i,
  input  logic [fdtd_pkg::GAIN_B_BITS-1:0]       gain_b_i,
  input  logic signed [fdtd_pkg::IO_BITS-1:0]    source_i,
  input  logic signed [W-1:0]                    h_left_i,
  input  logic signed [W-1:0]                    e_right_i,
  input  logic signed [W-1:0]                    bnd_i,
  output logic signed [W-1:0]                    e_o,
  output logic signed [W-1:0]                    h_o
);

  localparam int PW = W + 26;
  localparam logic signed [PW-1:0] SHI = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] SLO = ~SHI;
  localparam logic signed [PW-1:0] RND = PW'(32768);
  localparam bit FIRST  = (IDX == 0);
  localparam bit LAST   = (IDX == CELLS - 1);
  localparam bit SOURCE = (IDX == 1);

  logic signed [W-1:0] d_q, e_q, i_q, h_q;

  logic                 diel;
  logic signed [17:0]   ga_s;
  logic signed [24:0]   gb_s;
  logic signed [PW-1:0] dh, d1, d2;
  logic signed [W:0]    diff;
  logic signed [W+18:0] prod_a;
  logic signed [W+25:0] prod_b;
  logic signed [PW-1:0] e_new, i_new, dhh, h_new;

  function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SHI) r = SHI[W-1:0];
    else if (v < SLO) r = SLO[W-1:0];
    else r = v[W-1:0];
    return r;
  endfunction

  // Per-cell gains: vacuum below the dielectric start.
  assign diel = (IDX >= int'(diel_start_i));
  assign ga_s = diel ? $signed({1'b0, gain_a_i}) : 18'sd65536;
  assign gb_s = diel ? $signed({1'b0, gain_b_i}) : 25'sd0;

  // Flux update, with source injection on cell one.
  assign dh = (PW'(h_left_i) - PW'(h_q)) >>> 1;
  assign d1 = PW'(sat(PW'(d_q) + dh));
  assign d2 = SOURCE ? PW'(sat(d1 + PW'(source_i))) : d1;

  // Electric field from flux minus conduction integral.
  assign diff   = (W+1)'(d_q) - (W+1)'(i_q);
  assign prod_a = diff * ga_s;
  assign e_new  = (PW'(prod_a) + RND) >>> 16;

  // Conduction integral from the registered E.
  assign prod_b = e_q * gb_s;
  assign i_new  = PW'(i_q) + ((PW'(prod_b) + RND) >>> 16);

  // Magnetic field from the E curl.
  assign dhh   = (PW'(e_q) - PW'(e_right_i)) >>> 1;
  assign h_new = PW'(h_q) + dhh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
      e_q <= '0;
      i_q <= '0;
      h_q <= '0;
    end else begin
      if (ctl_i.flux && !FIRST) begin
        d_q <= d2[W-1:0];
      end
      if (ctl_i.efld && !FIRST) begin
        e_q <= sat(e_new);
      end
      if (ctl_i.cond) begin
        if (FIRST || LAST) begin
          e_q <= bnd_i;
        end
        if (!FIRST) begin
          i_q <= sat(i_new);
        end
      end
      if (ctl_i.magn && !LAST) begin
        h_q <= sat(h_new);
      end
    end
  end

  assign e_o = e_q;
  assign h_o = h_q;

endmodule

[design/fdtd_1d_lossy_field_update_top.sv]
// Top level of the 1-D lossy FDTD grid: sequencer, edge delays, cell row, read port.
`timescale 1ns / 1ps
// An advance item (cmd 0) runs in phases: the flux phase runs on the accepting
// edge, then the E, conduction/boundary and H phases run in the states ST_EFLD,
// ST_COND and ST_MAGN, all cells of the row working in parallel; busy is high
// in those states. A read item (cmd 1) leaves the block idle; its result is
// shown with valid_o on the next cycle, for that cycle only; the receiver cannot
// stall. Configuration writes are always ready and must be made while idle.
module fdtd_1d_lossy_field_update_top #(
  parameter int CELLS      = fdtd_pkg::CELLS_DEF,
  parameter int FIELD_BITS = fdtd_pkg::FIELD_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     cmd_i,
  input  logic signed [fdtd_pkg::IO_BITS-1:0]      source_i,
  input  logic [fdtd_pkg::IDX_BITS-1:0]            cell_index_i,
  output logic                                     valid_o,
  output logic signed [fdtd_pkg::IO_BITS-1:0]      e_value_o,
  output logic signed [fdtd_pkg::IO_BITS-1:0]      h_value_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [fdtd_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [fdtd_pkg::CFG_DATA_BITS-1:0]       cfg_data_i
);

  localparam int W  = FIELD_BITS;
  localparam int IW = $clog2(CELLS);
  localparam int XW = W + 25;
  localparam logic signed [XW-1:0] OHI = XW'(8388607);
  localparam logic signed [XW-1:0] OLO = ~OHI;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EFLD,
    ST_COND,
    ST_MAGN
  } state_e;

  state_e state_q;

  logic [fdtd_pkg::DSTART_BITS-1:0] dstart_q;
  logic [fdtd_pkg::GAIN_A_BITS-1:0] gain_a_q;
  logic [fdtd_pkg::GAIN_B_BITS-1:0] gain_b_q;

  logic signed [W-1:0] low0_q, low1_q, high0_q, high1_q;
  logic signed [W-1:0] e_w [CELLS];
  logic signed [W-1:0] h_w [CELLS];

  fdtd_pkg::fdtd_ctl_t ctl;
  logic                accept;
  logic [IW-1:0]       rd_idx;
  logic                in_grid;

  function automatic logic signed [fdtd_pkg::IO_BITS-1:0] sat_out(
    input logic signed [W-1:0] v);
    logic signed [XW-1:0] x;
    logic signed [fdtd_pkg::IO_BITS-1:0] r;
    x = XW'(v);
    if (x > OHI) r = OHI[fdtd_pkg::IO_BITS-1:0];
    else if (x < OLO) r = OLO[fdtd_pkg::IO_BITS-1:0];
    else r = x[fdtd_pkg::IO_BITS-1:0];
    return r;
  endfunction

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Decode phase strobes for the cell row.
  assign ctl.flux = accept && (cmd_i == fdtd_pkg::CMD_ADVANCE);
  assign ctl.efld = (state_q == ST_EFLD);
  assign ctl.cond = (state_q == ST_COND);
  assign ctl.magn = (state_q == ST_MAGN);

  // Sequence the phases of one time step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: if (ctl.flux) state_q <= ST_EFLD;
        ST_EFLD: state_q <= ST_COND;
        ST_COND: state_q <= ST_MAGN;
        ST_MAGN: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstart_q <= fdtd_pkg::DSTART_RST;
      gain_a_q <= fdtd_pkg::GAIN_A_RST;
      gain_b_q <= fdtd_pkg::GAIN_B_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fdtd_pkg::REG_DIEL_START: dstart_q <= cfg_data_i[fdtd_pkg::DSTART_BITS-1:0];
        fdtd_pkg::REG_GAIN_A:     gain_a_q <= cfg_data_i[fdtd_pkg::GAIN_A_BITS-1:0];
        fdtd_pkg::REG_GAIN_B:     gain_b_q <= cfg_data_i[fdtd_pkg::GAIN_B_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the two-step absorbing boundary delays.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low0_q  <= '0;
      low1_q  <= '0;
      high0_q <= '0;
      high1_q <= '0;
    end else if (ctl.cond) begin
      low0_q  <= low1_q;
      low1_q  <= e_w[1];
      high0_q <= high1_q;
      high1_q <= e_w[CELLS-2];
    end
  end

  // Row of cells.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic signed [W-1:0] h_left, e_right, bnd;
    if (k == 0) begin : g_lo
      assign h_left = '0;
      assign bnd    = low0_q;
    end else begin : g_mid_l
      assign h_left = h_w[k-1];
      assign bnd    = (k == CELLS - 1) ? high0_q : '0;
    end
    if (k == CELLS - 1) begin : g_hi
      assign e_right = '0;
    end else begin : g_mid_r
      assign e_right = e_w[k+1];
    end
    fdtd_cell #(
      .W     (W),
      .IDX   (k),
      .CELLS (CELLS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .diel_start_i (dstart_q),
      .gain_a_i     (gain_a_q),
      .gain_b_i     (gain_b_q),
      .source_i     (source_i),
      .h_left_i     (h_left),
      .e_right_i    (e_right),
      .bnd_i        (bnd),
      .e_o          (e_w[k]),
      .h_o          (h_w[k])
    );
  end

  // Read one cell into the result register.
  assign rd_idx  = IW'(cell_index_i);
  assign in_grid = (int'(cell_index_i) < CELLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= accept && (cmd_i == fdtd_pkg::CMD_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == fdtd_pkg::CMD_READ)) begin
      e_value_o <= in_grid ? sat_out(e_w[rd_idx]) : '0;
      h_value_o <= in_grid ? sat_out(h_w[rd_idx]) : '0;
    end
  end

endmodule

[design/fdtd_chk.sv]
// Port-level checker for the FDTD grid and its bind to the top level.
`timescale 1ns / 1ps
module fdtd_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cmd_i,
  input logic valid_o
);

  // A result follows only a read transfer.
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy && cmd_i == fdtd_pkg::CMD_READ))
    else $error("result without read transfer");

  // An advance transfer makes the block busy and yields no result.
  a_adv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == fdtd_pkg::CMD_ADVANCE) |=> (busy && !valid_o))
    else $error("advance did not start");

  // A time step holds busy through the E, conduction and H phases, then drops it.
  a_busy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> busy ##1 busy ##1 busy ##1 !busy)
    else $error("wrong time step length");

  // No result while a time step runs.
  a_no_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !valid_o)
    else $error("result during time step");

endmodule

bind fdtd_1d_lossy_field_update_top fdtd_chk u_fdtd_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .cmd_i   (cmd_i),
  .valid_o (valid_o)
);

[bench/fdtd_1d_lossy_field_update_top_test.sv]
// Testbench for the 1-D lossy FDTD grid: predicts each read from a bit-exact grid model.
`timescale 1ns / 1ps
module fdtd_1d_lossy_field_update_top_test;
  import fdtd_pkg::*;

  localparam int NCELL = 64;
  localparam longint FMAX = 64'sd8388607;
  localparam longint FMIN = -64'sd8388608;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic signed [IO_BITS-1:0] e;
    logic signed [IO_BITS-1:0] h;
  } cell_read_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cmd_i = CMD_ADVANCE;
  logic signed [IO_BITS-1:0] source_i = '0;
  logic [IDX_BITS-1:0] cell_index_i = '0;
  logic valid_o;
  logic signed [IO_BITS-1:0] e_value_o, h_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = REG_DIEL_START;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  // Grid model state and register copies.
  longint flux_d[NCELL], efield[NCELL], cond_int[NCELL], hfield[NCELL];
  longint low_dly[2], high_dly[2];
  longint diel_start, gain_a, gain_b;

  cell_read_t expected_reads[$];
  int errors = 0;
  bit gaps_on = 1'b1;

  always #2 clk_i = ~clk_i;

  fdtd_1d_lossy_field_update_top i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .source_i, .cell_index_i,
    .valid_o, .e_value_o, .h_value_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  function automatic longint sat24(longint v);
    if (v > FMAX) return FMAX;
    if (v < FMIN) return FMIN;
    return v;
  endfunction

  // Advance the model grid by one time step.
  function automatic void field_advance(longint src);
    longint ga, gb, e;
    for (int k = 1; k < NCELL; k++)
      flux_d[k] = sat24(flux_d[k] + ((hfield[k-1] - hfield[k]) >>> 1));
    flux_d[1] = sat24(flux_d[1] + src);
    for (int k = 1; k < NCELL; k++) begin
      ga = (k >= diel_start) ? gain_a : 65536;
      gb = (k >= diel_start) ? gain_b : 0;
      e = sat24((ga * (flux_d[k] - cond_int[k]) + 32768) >>> 16);
      efield[k] = e;
      cond_int[k] = sat24(cond_int[k] + ((gb * e + 32768) >>> 16));
    end
    efield[0] = low_dly[0];
    low_dly[0] = low_dly[1];
    low_dly[1] = efield[1];
    efield[NCELL-1] = high_dly[0];
    high_dly[0] = high_dly[1];
    high_dly[1] = efield[NCELL-2];
    for (int k = 0; k < NCELL - 1; k++)
      hfield[k] = sat24(hfield[k] + ((efield[k] - efield[k+1]) >>> 1));
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Send one item; hold start high afterwards so back-to-back transfers stay possible.
  task automatic send_item(logic cmd, logic signed [IO_BITS-1:0] src, logic [IDX_BITS-1:0] idx);
    cell_read_t r;
    if (gaps_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    source_i <= src;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy);
    if (cmd == CMD_ADVANCE) begin
      field_advance(longint'(src));
    end else begin
      r.e = efield[idx][IO_BITS-1:0];
      r.h = hfield[idx][IO_BITS-1:0];
      expected_reads.push_back(r);
    end
  endtask

  // Drop start, drain pending reads and let any advance finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DATA_BITS-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DIEL_START: diel_start = val & 64'h3f;
      REG_GAIN_A:     gain_a = val & 64'h1ffff;
      default:        gain_b = val & 64'hffffff;
    endcase
  endtask

  task automatic set_grid(longint ds, longint ga, longint gb);
    settle();
    write_reg(REG_DIEL_START, ds);
    write_reg(REG_GAIN_A, ga);
    write_reg(REG_GAIN_B, gb);
  endtask

  function automatic logic signed [IO_BITS-1:0] rand_source();
    case ($urandom_range(9))
      0:       return FMAX[IO_BITS-1:0];
      1:       return FMIN[IO_BITS-1:0];
      2, 3:    return IO_BITS'($urandom);
      default: return IO_BITS'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  // Check each read result against the oldest prediction.
  always @(posedge clk_i) begin
    cell_read_t x;
    if (rst_ni && valid_o) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("read result with none pending");
      end else begin
        x = expected_reads.pop_front();
        if (e_value_o !== x.e)
          report_mismatch($sformatf("e_value %0d, want %0d", e_value_o, x.e));
        if (h_value_o !== x.h)
          report_mismatch($sformatf("h_value %0d, want %0d", h_value_o, x.h));
      end
    end
  end

  // Reads of a clean grid, both ends included.
  task automatic test_reset_reads();
    send_item(CMD_READ, '0, 6'd0);
    send_item(CMD_READ, '0, 6'd63);
    send_item(CMD_READ, '1, 6'd32);
  endtask

  // Extreme sources and reads at the edges and the region boundary.
  task automatic test_directed();
    send_item(CMD_ADVANCE, FMAX[IO_BITS-1:0], 6'd0);
    send_item(CMD_ADVANCE, FMAX[IO_BITS-1:0], 6'd63);
    send_item(CMD_READ, '0, 6'd1);
    send_item(CMD_ADVANCE, FMIN[IO_BITS-1:0], 6'd0);
    for (int i = 0; i < 4; i++) send_item(CMD_ADVANCE, '0, 6'd0);
    send_item(CMD_READ, '0, 6'd0);
    send_item(CMD_READ, '0, 6'd62);
    send_item(CMD_READ, '0, 6'd63);
    set_grid(0, 0, 24'hffffff);
    send_item(CMD_ADVANCE, 24'h012345, 6'd0);
    send_item(CMD_ADVANCE, 24'h054321, 6'd0);
    send_item(CMD_READ, '0, 6'd1);
    set_grid(63, 131071, 65536);
    send_item(CMD_ADVANCE, FMIN[IO_BITS-1:0], 6'd0);
    send_item(CMD_READ, '0, 6'd63);
    send_item(CMD_READ, '0, 6'd2);
  endtask

  // Random phases, each under a fresh grid setting; one phase runs without gaps.
  task automatic test_random();
    longint ds, ga, gb;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin ds = 32; ga = 65536; gb = 0; end
        1: begin ds = 0; ga = 40000; gb = 655; end
        2: begin ds = 63; ga = 131071; gb = 16777215; end
        default: begin
          ds = $urandom_range(63); ga = $urandom_range(131071);
          gb = $urandom_range(1, 1000) * (($urandom_range(3) == 0) ? 5000 : 1);
        end
      endcase
      set_grid(ds, ga, gb);
      gaps_on = (ph != 3);
      for (int i = 0; i < 270; i++) begin
        if ($urandom_range(1)) send_item(CMD_ADVANCE, rand_source(), IDX_BITS'($urandom));
        else send_item(CMD_READ, IO_BITS'($urandom), IDX_BITS'($urandom_range(63)));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (flux_d[k]) begin
      flux_d[k] = 0; efield[k] = 0; cond_int[k] = 0; hfield[k] = 0;
    end
    low_dly = '{0, 0};
    high_dly = '{0, 0};
    diel_start = DSTART_RST;
    gain_a = GAIN_A_RST;
    gain_b = GAIN_B_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_reads();
    test_directed();
    test_random();
    settle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop for a hung run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
